### hw/rtl/nscale_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nscale_pkg: shared types and constants of the nearest-neighbor scaler
// Request and result payloads, register indexes, command codes and widths.
// ----------------------------------------------------------------------------
package nscale_pkg;

	localparam int unsigned STORE_PIXELS_DEF = 65536;
	localparam int unsigned MAX_SOURCE_DIM   = 8192;
	localparam int unsigned MAX_TARGET_DIM   = 4096;

	localparam int unsigned SRC_DIM_W = 14;
	localparam int unsigned DST_DIM_W = 13;
	localparam int unsigned COORD_W   = 12;
	localparam int unsigned PIX_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 14;

	// source address: row base (< 2^26) plus column
	localparam int unsigned ADDR_W = 27;
	// dividend of the setup divider: coordinate times source dimension
	localparam int unsigned DIVD_W = 26;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_out;
		logic [COORD_W-1:0] out_col;
		logic [COORD_W-1:0] out_row;
		logic               frame_end;
	} rsp_t;

	function automatic logic [PIX_W-1:0] pack565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	function automatic logic [SRC_DIM_W-1:0] clamp_src(logic [SRC_DIM_W-1:0] v);
		logic [SRC_DIM_W-1:0] res;
		if (v == '0) begin
			res = SRC_DIM_W'(1);
		end else if (v > SRC_DIM_W'(MAX_SOURCE_DIM)) begin
			res = SRC_DIM_W'(MAX_SOURCE_DIM);
		end else begin
			res = v;
		end
		return res;
	endfunction

	function automatic logic [DST_DIM_W-1:0] clamp_dst(logic [DST_DIM_W-1:0] v);
		logic [DST_DIM_W-1:0] res;
		if (v == '0) begin
			res = DST_DIM_W'(1);
		end else if (v > DST_DIM_W'(MAX_TARGET_DIM)) begin
			res = DST_DIM_W'(MAX_TARGET_DIM);
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/nearest_scale_rgba_to_rgb565.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_scale_rgba_to_rgb565: nearest-neighbor image scaler to RGB565
// Loads source pixels into a frame store and emits the scaled image in
// raster order, stepping source coordinates incrementally.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | request   | in_valid / in_ready     | in_data  (nscale_pkg::req_t)
//  out     | result    | out_valid / out_ready   | out_data (nscale_pkg::rsp_t)
//  cfg     | write     | cfg_write               | cfg_index, cfg_data
//
// A load is written to the frame store when taken; an emit passes the frame
// store read register, then the output register, as the frame store is
// single-port with a registered read. The first emit after reset or after
// any register write first runs a setup pass (one shared multiplier, a
// 26-step radix-2 divider run four times) that rebuilds the step increments.
// Reset clears the counters and the registers to width and height 1; the
// frame store is not cleared. A stalled result holds in the output register
// while loads keep being taken.
// ----------------------------------------------------------------------------
module nearest_scale_rgba_to_rgb565 #(
	parameter int unsigned STORE_PIXELS = nscale_pkg::STORE_PIXELS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire  nscale_pkg::req_t                in_data,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output nscale_pkg::rsp_t                      out_data,
	input  wire                                   cfg_write,
	input  wire  [nscale_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [nscale_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned AW = $clog2(STORE_PIXELS);
	localparam int unsigned LW = $clog2(STORE_PIXELS + 1);
	localparam int unsigned SW = nscale_pkg::SRC_DIM_W;
	localparam int unsigned TW = nscale_pkg::DST_DIM_W;
	localparam int unsigned CW = nscale_pkg::COORD_W;
	localparam int unsigned XW = nscale_pkg::ADDR_W;
	localparam int unsigned DW = nscale_pkg::DIVD_W;
	localparam int unsigned PW = nscale_pkg::PIX_W;
	localparam int unsigned MW = 2 * SW;
	localparam int unsigned NW = $clog2(DW);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RESP = 6'b000010,
		S_NORM = 6'b000100,
		S_MUL  = 6'b001000,
		S_DIV  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		OP_SX   = 3'd0,
		OP_QX   = 3'd1,
		OP_SY   = 3'd2,
		OP_QY   = 3'd3,
		OP_BASE = 3'd4,
		OP_STEP = 3'd5
	} setup_op_t;

	state_t    state_q;
	setup_op_t op_q;
	logic [NW-1:0] div_cnt_q;
	logic          dirty_q;

	logic [SW-1:0] src_w_q, src_h_q;
	logic [TW-1:0] dst_w_q, dst_h_q;
	logic [LW-1:0] load_addr_q;
	logic [CW-1:0] col_q, row_q;

	// incremental stepping state, rebuilt by setup
	logic [TW-1:0] sx_q, sy_q;
	logic [CW-1:0] accx_q, accy_q;
	logic [SW-1:0] qx_q, qy_q;
	logic [CW-1:0] rx_q, ry_q;
	logic [XW-1:0] row_base_q, qysw_q, qysw1_q;

	logic [DW-1:0] dvd_q;
	logic [SW-1:0] rem_q;

	logic [PW-1:0] store_mem [STORE_PIXELS];
	logic [PW-1:0] rd_data_q;

	logic [CW-1:0] col_s1, row_s1;
	logic          last_s1, hit_s1;

	logic          out_valid_q;
	nscale_pkg::rsp_t out_data_q;

	logic [SW-1:0] sw_c, sh_c;
	logic [TW-1:0] tw_c, th_c;
	logic          col_end, row_end;
	logic [TW-1:0] accx_sum, accy_sum;
	logic          cx, cy;
	logic [CW-1:0] accx_nx, accy_nx;
	logic [TW-1:0] sx_nx, sy_nx;
	logic [XW-1:0] base_nx, src_addr;
	logic          src_hit;
	logic          accept, load_acc, emit_acc, load_ok;
	logic [SW-1:0] mul_a, mul_b;
	logic [MW-1:0] mul_p;
	logic [TW-1:0] div_by;
	logic [SW-1:0] rem_sh, rem_nx;
	logic          div_ge;
	logic [DW-1:0] quo_nx;
	logic [TW-1:0] row_inc;

	always_comb begin
		sw_c = nscale_pkg::clamp_src(src_w_q);
		sh_c = nscale_pkg::clamp_src(src_h_q);
		tw_c = nscale_pkg::clamp_dst(dst_w_q);
		th_c = nscale_pkg::clamp_dst(dst_h_q);

		col_end = {1'b0, col_q} == tw_c - TW'(1);
		row_end = {1'b0, row_q} == th_c - TW'(1);

		accx_sum = {1'b0, accx_q} + {1'b0, rx_q};
		cx       = accx_sum >= tw_c;
		accx_nx  = cx ? CW'(accx_sum - tw_c) : CW'(accx_sum);
		sx_nx    = TW'(SW'(sx_q) + qx_q + SW'(cx));

		accy_sum = {1'b0, accy_q} + {1'b0, ry_q};
		cy       = accy_sum >= th_c;
		accy_nx  = cy ? CW'(accy_sum - th_c) : CW'(accy_sum);
		sy_nx    = TW'(SW'(sy_q) + qy_q + SW'(cy));
		base_nx  = row_base_q + (cy ? qysw1_q : qysw_q);

		src_addr = row_base_q + XW'(sx_q);
		src_hit  = src_addr < XW'(STORE_PIXELS);
		load_ok  = load_addr_q < LW'(STORE_PIXELS);
		row_inc  = {1'b0, row_q} + TW'(1);
	end

	// emits wait for a clean setup, no register write and a free output slot
	always_comb begin
		in_ready = 1'b0;
		if (state_q == S_IDLE) begin
			if (in_data.cmd == nscale_pkg::CMD_LOAD) begin
				in_ready = 1'b1;
			end else begin
				in_ready = !dirty_q && !cfg_write && (!out_valid_q || out_ready);
			end
		end
	end

	assign accept   = in_valid && in_ready;
	assign load_acc = accept && (in_data.cmd == nscale_pkg::CMD_LOAD);
	assign emit_acc = accept && (in_data.cmd == nscale_pkg::CMD_EMIT);

	always_comb begin
		unique case (op_q)
			OP_SX: begin
				mul_a = SW'(col_q);
				mul_b = sw_c;
			end
			OP_QX: begin
				mul_a = sw_c;
				mul_b = SW'(1);
			end
			OP_SY: begin
				mul_a = SW'(row_q);
				mul_b = sh_c;
			end
			OP_QY: begin
				mul_a = sh_c;
				mul_b = SW'(1);
			end
			OP_BASE: begin
				mul_a = SW'(sy_q);
				mul_b = sw_c;
			end
			OP_STEP: begin
				mul_a = qy_q;
				mul_b = sw_c;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;

		div_by = ((op_q == OP_SX) || (op_q == OP_QX)) ? tw_c : th_c;
		rem_sh = {rem_q[SW-2:0], dvd_q[DW-1]};
		div_ge = rem_sh >= SW'(div_by);
		rem_nx = div_ge ? rem_sh - SW'(div_by) : rem_sh;
		quo_nx = {dvd_q[DW-2:0], div_ge};
	end

	// control, counters and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_SX;
			div_cnt_q   <= '0;
			dirty_q     <= 1'b1;
			src_w_q     <= SW'(1);
			src_h_q     <= SW'(1);
			dst_w_q     <= TW'(1);
			dst_h_q     <= TW'(1);
			load_addr_q <= '0;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				dirty_q <= 1'b1;
				unique case (cfg_index)
					nscale_pkg::REG_SOURCE_WIDTH:  src_w_q <= cfg_data;
					nscale_pkg::REG_SOURCE_HEIGHT: src_h_q <= cfg_data;
					nscale_pkg::REG_TARGET_WIDTH:  dst_w_q <= TW'(cfg_data);
					nscale_pkg::REG_TARGET_HEIGHT: dst_h_q <= TW'(cfg_data);
					default: ;
				endcase
			end

			if (load_acc && load_ok) begin
				load_addr_q <= load_addr_q + LW'(1);
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (emit_acc) begin
						state_q <= S_RESP;
						if (col_end) begin
							col_q <= '0;
							row_q <= row_end ? '0 : row_q + CW'(1);
						end else begin
							col_q <= col_q + CW'(1);
						end
					end else if (dirty_q && in_valid && !cfg_write
						&& (in_data.cmd == nscale_pkg::CMD_EMIT)) begin
						state_q <= S_NORM;
					end
				end
				S_RESP: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_NORM: begin
					// fold counters left past a shrunken target back in range
					if (cfg_write) begin
						state_q <= S_IDLE;
					end else begin
						if ({1'b0, col_q} >= tw_c) begin
							col_q <= '0;
							row_q <= (row_inc >= th_c) ? '0 : CW'(row_inc);
						end else if ({1'b0, row_q} >= th_c) begin
							row_q <= '0;
						end
						op_q    <= OP_SX;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (cfg_write) begin
						state_q <= S_IDLE;
					end else if (op_q == OP_STEP) begin
						state_q <= S_FIN;
					end else if (op_q == OP_BASE) begin
						op_q <= OP_STEP;
					end else begin
						div_cnt_q <= NW'(DW - 1);
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					if (cfg_write) begin
						state_q <= S_IDLE;
					end else if (div_cnt_q == '0) begin
						op_q    <= setup_op_t'(op_q + 3'd1);
						state_q <= S_MUL;
					end else begin
						div_cnt_q <= div_cnt_q - NW'(1);
					end
				end
				S_FIN: begin
					if (cfg_write) begin
						state_q <= S_IDLE;
					end else begin
						dirty_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// stepping state, setup datapath and result staging
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (emit_acc) begin
					col_s1  <= col_q;
					row_s1  <= row_q;
					last_s1 <= col_end && row_end;
					hit_s1  <= src_hit;
					if (col_end) begin
						sx_q   <= '0;
						accx_q <= '0;
						if (row_end) begin
							sy_q       <= '0;
							accy_q     <= '0;
							row_base_q <= '0;
						end else begin
							sy_q       <= sy_nx;
							accy_q     <= accy_nx;
							row_base_q <= base_nx;
						end
					end else begin
						sx_q   <= sx_nx;
						accx_q <= accx_nx;
					end
				end
			end
			S_RESP: begin
				out_data_q.pixel_out <= hit_s1 ? rd_data_q : '0;
				out_data_q.out_col   <= col_s1;
				out_data_q.out_row   <= row_s1;
				out_data_q.frame_end <= last_s1;
			end
			S_MUL: begin
				dvd_q <= DW'(mul_p);
				rem_q <= '0;
				if (op_q == OP_BASE) begin
					row_base_q <= XW'(mul_p);
				end
				if (op_q == OP_STEP) begin
					qysw_q <= XW'(mul_p);
				end
			end
			S_DIV: begin
				dvd_q <= quo_nx;
				rem_q <= rem_nx;
				if (div_cnt_q == '0) begin
					unique case (op_q)
						OP_SX: begin
							sx_q   <= TW'(quo_nx);
							accx_q <= CW'(rem_nx);
						end
						OP_QX: begin
							qx_q <= SW'(quo_nx);
							rx_q <= CW'(rem_nx);
						end
						OP_SY: begin
							sy_q   <= TW'(quo_nx);
							accy_q <= CW'(rem_nx);
						end
						OP_QY: begin
							qy_q <= SW'(quo_nx);
							ry_q <= CW'(rem_nx);
						end
						default: ;
					endcase
				end
			end
			S_FIN: begin
				qysw1_q <= qysw_q + XW'(sw_c);
			end
			default: ;
		endcase
	end

	// frame store: one port, write on load, read on emit
	always_ff @(posedge clk) begin
		if (load_acc && load_ok) begin
			store_mem[load_addr_q[AW-1:0]] <= nscale_pkg::pack565(in_data.red_in,
				in_data.green_in, in_data.blue_in);
		end
		if (emit_acc) begin
			rd_data_q <= store_mem[src_addr[AW-1:0]];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire
